### rtl/cgcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgcp_pkg
// shared types and constants of the gateway command parser
// ----------------------------------------------------------------------------
package cgcp_pkg;

    localparam int MAX_FRAME_BYTES = 8;

    localparam logic [7:0] SYNC_BYTE   = 8'hF1;
    localparam logic [7:0] BINARY_BYTE = 8'hE7;
    localparam logic [19:0] SPEED_MAX  = 20'd1000000;
    localparam logic [19:0] SPEED_RST  = 20'd500000;

    localparam logic [2:0] KIND_REPLY   = 3'd0;
    localparam logic [2:0] KIND_SEND    = 3'd1;
    localparam logic [2:0] KIND_ECHO    = 3'd2;
    localparam logic [2:0] KIND_CONSOLE = 3'd3;
    localparam logic [2:0] KIND_BUS     = 3'd4;

    localparam logic [0:0] REG_BUILD  = 1'd0;
    localparam logic [0:0] REG_BUSCNT = 1'd1;

    localparam logic [7:0] CMD_BUILD   = 8'd0;
    localparam logic [7:0] CMD_TIME    = 8'd1;
    localparam logic [7:0] CMD_DIG     = 8'd2;
    localparam logic [7:0] CMD_ANALOG  = 8'd3;
    localparam logic [7:0] CMD_DIGOUT  = 8'd4;
    localparam logic [7:0] CMD_SETUP   = 8'd5;
    localparam logic [7:0] CMD_GETBUS  = 8'd6;
    localparam logic [7:0] CMD_INFO    = 8'd7;
    localparam logic [7:0] CMD_SINGLE  = 8'd8;
    localparam logic [7:0] CMD_KEEP    = 8'd9;
    localparam logic [7:0] CMD_SYSTYPE = 8'd10;
    localparam logic [7:0] CMD_ECHO    = 8'd11;
    localparam logic [7:0] CMD_NBUS    = 8'd12;
    localparam logic [7:0] CMD_EXTBUS  = 8'd13;
    localparam logic [7:0] CMD_EXTSET  = 8'd14;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_CMD     = 8'b0000_0010,
        ST_BUILD   = 8'b0000_0100,
        ST_SKIP1   = 8'b0000_1000,
        ST_SETUP   = 8'b0001_0000,
        ST_SYSTYPE = 8'b0010_0000,
        ST_ECHO    = 8'b0100_0000,
        ST_EXT     = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic [31:0] now_us;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [30:0] frame_id;
        logic        extended;
        logic        bus_index;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic        bus_enable;
        logic        bus_listen_only;
        logic [19:0] bus_speed;
        logic        last;
    } t_out;

    // one parsed byte's emit job
    typedef struct packed {
        logic        reply;      // emit reply run
        logic [4:0]  reply_len;
        logic [16:0][7:0] reply_bytes;
        logic        single;     // emit one non-reply row
        t_out        row;
    } t_job;

endpackage
`default_nettype wire

### rtl/cgcp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgcp_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
interface cgcp_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/can_gateway_command_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_gateway_command_parser
// host byte command parser for a can gateway
// ----------------------------------------------------------------------------
// channels: i_in carries one byte item {in_byte, now_us}; o_out carries
// result items; i_cfg writes build_number (index 0) or bus_count (index 1).
// a byte is parsed in the cycle it is accepted and its job lands in the
// emitter register; result rows leave from the next cycle, one per cycle
// while o_out is ready. a byte with no results frees the block at once,
// so such bytes go every cycle; a byte with results holds the input off
// while the emitter plays the rows out (reply runs up to 17 rows)
// a new byte is taken in the cycle the last row of the previous one leaves
// when the receiver stalls, the current row holds and input is held off
// reset clears the parser to idle, bus settings to disabled at 500000
// ----------------------------------------------------------------------------
module can_gateway_command_parser import cgcp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cgcp_if.sink      i_in,
    cgcp_if.sink      i_cfg,
    cgcp_if.source    o_out
);
    logic [15:0] r_build;
    logic [1:0]  r_bus_count;
    t_job        job;
    logic        busy, go, ovalid, lastgo;
    t_out        row;
    t_in         item;
    logic [0:0]  cidx;

    assign item = t_in'(i_in.data);
    // take a byte when idle or as the last row leaves
    assign lastgo = ovalid && o_out.ready && row.last;
    assign i_in.ready = !busy || lastgo;
    assign go = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cidx = i_cfg.data[16 +: 1];

    cgcp_parser u_parser (
        .i_clk, .i_rst_n, .i_go(go), .i_item(item),
        .i_build(r_build), .i_bus_count(r_bus_count), .o_job(job)
    );

    cgcp_emitter u_emit (
        .i_clk, .i_rst_n, .i_load(go), .i_job(job),
        .i_out_ready(o_out.ready), .o_busy(busy), .o_valid(ovalid), .o_row(row)
    );

    assign o_out.valid = ovalid;
    assign o_out.data  = $bits(o_out.data)'(row);

    // config data: [15:0] value, [16] index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build <= '0; r_bus_count <= 2'd2;
        end else if (i_cfg.valid) begin
            if (cidx == REG_BUILD) r_build <= i_cfg.data[15:0];
            else if (cidx == REG_BUSCNT) r_bus_count <= i_cfg.data[1:0];
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ovalid && !o_out.ready |=> ovalid)
        else $error("row dropped under stall");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ovalid && !(o_out.ready && row.last) |-> !i_in.ready)
        else $error("byte taken while rows pending");
endmodule
`default_nettype wire

### rtl/cgcp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgcp_parser
// command state machine, one accepted byte a cycle, produces an emit job
// ----------------------------------------------------------------------------
module cgcp_parser import cgcp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire t_in         i_item,
    input  wire logic [15:0] i_build,
    input  wire logic [1:0]  i_bus_count,
    output t_job             o_job
);
    t_state      r_state;
    logic [3:0]  r_step;
    logic [31:0] r_id;
    logic        r_ext;
    logic [1:0]  r_bus;
    logic [3:0]  r_len;
    logic [7:0]  r_bytes [MAX_FRAME_BYTES];
    logic [31:0] r_word;
    logic [1:0]  r_en, r_li;
    logic [19:0] r_rate [2];
    logic [7:0]  r_systype;
    logic        r_binary;

    t_state      n_state;
    logic [3:0]  n_step, n_len;
    logic [31:0] n_id, n_word;
    logic        n_ext;
    logic [1:0]  n_bus, n_en, n_li;
    logic [19:0] n_rate [2];
    logic [7:0]  v;
    logic [31:0] w;
    logic [19:0] spd;
    logic        bi, allow;
    logic [63:0] fd;
    logic        bw;
    logic [2:0]  bidx;

    assign v = i_item.in_byte;

    always_comb begin
        n_state = r_state; n_step = r_step; n_id = r_id; n_ext = r_ext;
        n_bus = r_bus; n_len = r_len; n_word = r_word;
        n_en = r_en; n_li = r_li; n_rate = r_rate;
        o_job = '0; w = '0; spd = '0; bi = 1'b0; allow = 1'b0; fd = '0;
        bw = 1'b0; bidx = r_step[2:0] - 3'd6;
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < r_len) fd[8*k +: 8] = r_bytes[k];
        end
        for (int k = 0; k < 17; k++) o_job.reply_bytes[k] = 8'h00;
        o_job.reply_bytes[0] = SYNC_BYTE;
        o_job.reply_bytes[1] = v;
        case (r_state)
            ST_IDLE: begin
                if (v == SYNC_BYTE) n_state = ST_CMD;
                else if (v != BINARY_BYTE) begin
                    o_job.single = 1'b1;
                    o_job.row.kind = KIND_CONSOLE;
                    o_job.row.data_byte = v;
                end
            end
            ST_CMD: begin
                n_step = r_step;
                case (v)
                    CMD_BUILD:   begin n_state = ST_BUILD; n_step = '0; end
                    CMD_TIME: begin
                        o_job.reply = 1'b1; o_job.reply_len = 5'd6;
                        for (int k = 0; k < 4; k++)
                            o_job.reply_bytes[2+k] = i_item.now_us[8*k +: 8];
                        n_state = ST_SKIP1; n_step = '0;
                    end
                    CMD_DIG: begin
                        o_job.reply = 1'b1; o_job.reply_len = 5'd4;
                        o_job.reply_bytes[3] = SYNC_BYTE ^ v;
                        n_state = ST_IDLE;
                    end
                    CMD_ANALOG: begin
                        o_job.reply = 1'b1; o_job.reply_len = 5'd17;
                        o_job.reply_bytes[16] = SYNC_BYTE ^ v;
                        n_state = ST_IDLE;
                    end
                    CMD_DIGOUT, CMD_SINGLE: begin n_state = ST_SKIP1; n_step = '0; end
                    CMD_SETUP:   begin n_state = ST_SETUP; n_step = '0; end
                    CMD_GETBUS: begin
                        o_job.reply = 1'b1; o_job.reply_len = 5'd12;
                        o_job.reply_bytes[2] = {3'b0, r_li[0], 3'b0, r_en[0]};
                        o_job.reply_bytes[7] = {3'b0, r_li[1], 3'b0, r_en[1]};
                        for (int k = 0; k < 4; k++) begin
                            o_job.reply_bytes[3+k] = 8'({12'b0, r_rate[0]} >> (8*k));
                            o_job.reply_bytes[8+k] = 8'({12'b0, r_rate[1]} >> (8*k));
                        end
                        n_state = ST_IDLE;
                    end
                    CMD_INFO: begin
                        o_job.reply = 1'b1; o_job.reply_len = 5'd8;
                        o_job.reply_bytes[2] = i_build[7:0];
                        o_job.reply_bytes[3] = i_build[15:8];
                        o_job.reply_bytes[4] = 8'h20;
                        n_state = ST_IDLE;
                    end
                    CMD_KEEP: begin
                        o_job.reply = 1'b1; o_job.reply_len = 5'd4;
                        o_job.reply_bytes[2] = 8'hDE; o_job.reply_bytes[3] = 8'hAD;
                        n_state = ST_IDLE;
                    end
                    CMD_SYSTYPE: begin n_state = ST_SYSTYPE; n_step = '0; end
                    CMD_ECHO:    begin n_state = ST_ECHO; n_step = '0; end
                    CMD_NBUS: begin
                        o_job.reply = 1'b1; o_job.reply_len = 5'd3;
                        o_job.reply_bytes[2] = {6'b0, i_bus_count};
                        n_state = ST_IDLE;
                    end
                    CMD_EXTBUS: begin
                        o_job.reply = 1'b1; o_job.reply_len = 5'd17;
                        n_step = '0; n_state = ST_IDLE;
                    end
                    CMD_EXTSET:  begin n_state = ST_EXT; n_step = '0; end
                    default: ;
                endcase
            end
            ST_BUILD, ST_ECHO: begin
                n_step = r_step + 4'd1;
                if (r_step < 4'd4) begin
                    if (r_step == 4'd0) n_id = {24'b0, v};
                    else n_id = r_id | ({24'b0, v} << {r_step[1:0], 3'b000});
                    if (r_step == 4'd3) begin
                        n_ext = n_id[31];
                        n_id[31] = 1'b0;
                    end
                end else if (r_step == 4'd4) begin
                    n_bus = (r_state == ST_ECHO) ? {1'b0, v[0]} : v[1:0];
                end else if (r_step == 4'd5) begin
                    n_len = (v[3:0] > 4'(MAX_FRAME_BYTES)) ? 4'(MAX_FRAME_BYTES) : v[3:0];
                end else if ({1'b0, r_step} < 5'd6 + {1'b0, r_len}) begin
                    bw = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                    if (r_state == ST_ECHO || r_bus < 2'd2) begin
                        o_job.single = 1'b1;
                        o_job.row.kind = (r_state == ST_ECHO) ? KIND_ECHO : KIND_SEND;
                        o_job.row.frame_id = r_id[30:0];
                        o_job.row.extended = r_ext;
                        o_job.row.bus_index = (r_state == ST_ECHO) ? 1'b0 : r_bus[0];
                        o_job.row.frame_len = r_len;
                        o_job.row.frame_data = fd;
                    end
                end
            end
            ST_SKIP1, ST_SYSTYPE: n_state = ST_IDLE;
            ST_SETUP: begin
                if (r_step[1:0] == 2'd0) n_word = {24'b0, v};
                else n_word = r_word | ({24'b0, v} << {r_step[1:0], 3'b000});
                n_step = {1'b0, r_step[2:0] + 3'd1};
                if (r_step[1:0] == 2'd3) begin
                    w = n_word;
                    bi = r_step[2];
                    allow = !bi || (i_bus_count > 2'd1);
                    spd = (w[19:0] > SPEED_MAX) ? SPEED_MAX : w[19:0];
                    if (w != 32'd0 && allow) begin
                        if (w[31]) begin
                            n_en[bi] = w[30]; n_li[bi] = w[29];
                        end else n_en[bi] = 1'b1;
                        n_rate[bi] = spd;
                    end else n_en[bi] = 1'b0;
                    o_job.single = 1'b1;
                    o_job.row.kind = KIND_BUS;
                    o_job.row.bus_index = bi;
                    o_job.row.bus_enable = n_en[bi];
                    o_job.row.bus_listen_only = n_li[bi];
                    o_job.row.bus_speed = n_rate[bi];
                    if (bi) n_state = ST_IDLE;
                end
            end
            ST_EXT: begin
                if (r_step >= 4'd11) n_state = ST_IDLE;
                n_step = r_step + 4'd1;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_step <= '0; r_id <= '0; r_ext <= 1'b0;
            r_bus <= '0; r_len <= '0; r_word <= '0; r_en <= '0; r_li <= '0;
            r_rate[0] <= SPEED_RST; r_rate[1] <= SPEED_RST;
            r_systype <= '0; r_binary <= 1'b0;
        end else if (i_go) begin
            r_state <= n_state; r_step <= n_step; r_id <= n_id; r_ext <= n_ext;
            r_bus <= n_bus; r_len <= n_len; r_word <= n_word;
            r_en <= n_en; r_li <= n_li; r_rate <= n_rate;
            if (r_state == ST_SYSTYPE) r_systype <= v;
            if (r_state == ST_IDLE && v == BINARY_BYTE) r_binary <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && bw) r_bytes[bidx] <= v;
    end

    // system type and binary mode are held for the host side; not reported
    logic unused_ok;
    assign unused_ok = ^{r_systype, r_binary};
endmodule
`default_nettype wire

### rtl/cgcp_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgcp_emitter
// holds one job and plays its result rows out, one per cycle while ready
// ----------------------------------------------------------------------------
module cgcp_emitter import cgcp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  wire t_job i_job,
    input  wire logic i_out_ready,
    output logic      o_busy,
    output logic      o_valid,
    output t_out      o_row
);
    logic       r_active;
    t_job       r_job;
    logic [4:0] r_idx;
    logic       fire, fin;

    assign o_busy  = r_active;
    assign o_valid = r_active;
    assign fire    = r_active && i_out_ready;
    assign fin     = !r_job.reply || (r_idx == r_job.reply_len - 5'd1);

    always_comb begin
        if (r_job.reply) begin
            o_row = '0;
            o_row.kind = KIND_REPLY;
            o_row.data_byte = r_job.reply_bytes[r_idx];
        end else o_row = r_job.row;
        o_row.last = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0; r_idx <= '0;
        end else if (i_load) begin
            r_active <= i_job.reply || i_job.single;
            r_idx <= '0;
        end else if (fire) begin
            if (fin) r_active <= 1'b0;
            r_idx <= r_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_job <= i_job;
    end
endmodule
`default_nettype wire
